// ===== src/gcd_pkg.sv =====
// Shared widths, fixed-point constants and the CORDIC arctangent table.
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 22;
    localparam int CORDIC_STAGES   = 28;
    localparam int SQ_STEPS        = 31;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int DIST_W = 28;
    localparam int RAD_W  = 23;

    localparam int XY_W  = 34;
    localparam int Z_W   = 45;
    localparam int SQ_W  = 62;
    localparam int C32_W = 35;

    localparam logic signed [Z_W-1:0] PI_Q40      = 45'sd3454217652358;
    localparam logic signed [Z_W-1:0] TWO_PI_Q40  = 45'sd6908435304716;
    localparam logic signed [Z_W-1:0] HALF_PI_Q40 = 45'sd1727108826179;

    // pi/180 in Q60, split into high and low words
    localparam logic [22:0] D2R_HI = 23'd4685082;
    localparam logic [31:0] D2R_LO = 32'd2303358180;

    localparam logic signed [XY_W-1:0] INV_K = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [DIST_W-1:0] MAX_DIST     = 28'd263540000;
    localparam logic [RAD_W-1:0]  RADIUS_RESET = 23'd6378137;

    // atan(2^-i) in Q40
    function automatic logic [Z_W-3:0] atan_q40(input int i);
        logic [Z_W-3:0] a;
        case (i)
            0:       a = 43'd863554413089;
            1:       a = 43'd509785937287;
            2:       a = 43'd269356888665;
            3:       a = 43'd136729762476;
            4:       a = 43'd68630207382;
            5:       a = 43'd34348560106;
            6:       a = 43'd17178471287;
            7:       a = 43'd8589759836;
            8:       a = 43'd4294945451;
            9:       a = 43'd2147480917;
            10:      a = 43'd1073741483;
            11:      a = 43'd536870869;
            12:      a = 43'd268435451;
            13:      a = 43'd134217727;
            default: a = 43'd1 << (40 - i);
        endcase
        return a;
    endfunction

endpackage

// ===== src/gcd_pts_if.sv =====
// Input channel: one pair of positions per transaction.
interface gcd_pts_if;
    logic                              valid;
    logic                              ready;
    logic signed [gcd_pkg::LAT_W-1:0]  lat_a;
    logic signed [gcd_pkg::LON_W-1:0]  lon_a;
    logic signed [gcd_pkg::LAT_W-1:0]  lat_b;
    logic signed [gcd_pkg::LON_W-1:0]  lon_b;

    modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                    input ready);
    modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                  output ready);
endinterface

// ===== src/gcd_dist_if.sv =====
// Output channel: one distance per transaction.
interface gcd_dist_if;
    logic                        valid;
    logic                        ready;
    logic [gcd_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

// ===== src/great_circle_distance.sv =====
// Haversine great-circle distance pipeline, top level.
//
// points: one transaction carries lat_a, lon_a, lat_b, lon_b in signed degrees * 2^22.
// result: one transaction per input transaction carries the distance in 0.0001 km,
//   rounded half away from zero and saturated at 263540000, in input order.
// cfg_wr_en / cfg_wr_data: write the earth radius in meters; write it only while idle.
// Pipeline: 5 angle setup stages, the sine/cosine CORDIC and its output register, 4 haversine
//   product stages, a 31-stage square root giving one digit per stage, the vectoring CORDIC,
//   3 scale stages; every stage is a register with its own valid bit.
// Throughput: one transaction per cycle while the pipeline is not stalled.
// Stall: when result.ready is low with a result pending, the whole pipeline holds;
//   points.ready drops in the same cycle, nothing is lost or repeated.
// Reset: valid bits clear, so the pipeline is empty; the radius returns to 6378137 m.
module great_circle_distance (
    input  logic                          clk,
    input  logic                          rst_n,
    gcd_pts_if.sink                       points,
    gcd_dist_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [gcd_pkg::RAD_W-1:0]     cfg_wr_data
);

    localparam int N   = gcd_pkg::CORDIC_STAGES;
    localparam int SQN = gcd_pkg::SQ_STEPS;
    localparam int LAT = 5 + N + 1 + 4 + SQN + N + 3;
    localparam int AFB = gcd_pkg::ANGLE_FRAC_BITS;
    localparam logic signed [35:0] ONE_S = 36'sd1073741824;

    logic                          en;
    logic [LAT-1:0]                vld_reg;
    logic [gcd_pkg::RAD_W-1:0]     earth_radius_m_reg;
    logic [gcd_pkg::RAD_W-1:0]     earth_radius_m_next;
    logic [26:0]                   rad10;

    assign en = !vld_reg[LAT-1] || result.ready;
    assign points.ready = en;

    assign earth_radius_m_next = cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            earth_radius_m_reg <= gcd_pkg::RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            earth_radius_m_reg <= earth_radius_m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], points.valid};
        end
    end

    // lanes: lat_a, lat_b, half dlat, half dlon
    logic signed [31:0] raw [4];
    assign raw[0] = 32'(points.lat_a);
    assign raw[1] = 32'(points.lat_b);
    assign raw[2] = 32'(points.lat_a) - 32'(points.lat_b);
    assign raw[3] = 32'(points.lon_a) - 32'(points.lon_b);

    logic [31:0]                    mag_reg [4];
    logic                           neg1_reg [4];
    logic [54:0]                    ph_reg [4];
    logic [63:0]                    pl_reg [4];
    logic                           neg2_reg [4];
    logic signed [gcd_pkg::Z_W-1:0] z3_reg [4];
    logic signed [gcd_pkg::Z_W-1:0] z4_reg [4];
    logic signed [gcd_pkg::Z_W-1:0] z5_reg [4];
    logic                           neg5_reg [4];
    logic signed [gcd_pkg::XY_W-1:0] sin_w [4];
    logic signed [gcd_pkg::XY_W-1:0] cos_w [4];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        localparam int SH = (k < 2) ? AFB - 12 : AFB - 11;
        localparam logic [55:0] RND = 56'd1 << (SH - 1);

        logic [31:0]                    mag_next;
        logic [55:0]                    sum;
        logic [gcd_pkg::Z_W-2:0]        zmag;
        logic signed [gcd_pkg::Z_W-1:0] z3_next;
        logic signed [gcd_pkg::Z_W-1:0] z4_next;
        logic signed [gcd_pkg::Z_W-1:0] z5_next;
        logic                           neg5_next;

        assign mag_next = raw[k] < 0 ? 32'(-raw[k]) : 32'(raw[k]);
        assign sum  = 56'(ph_reg[k]) + 56'(pl_reg[k][63:32]) + RND;
        assign zmag = (gcd_pkg::Z_W-1)'(sum >> SH);
        assign z3_next = neg2_reg[k] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});

        always_comb
        begin
            if (z3_reg[k] > gcd_pkg::PI_Q40)
                z4_next = z3_reg[k] - gcd_pkg::TWO_PI_Q40;
            else if (z3_reg[k] < -gcd_pkg::PI_Q40)
                z4_next = z3_reg[k] + gcd_pkg::TWO_PI_Q40;
            else
                z4_next = z3_reg[k];

            if (z4_reg[k] > gcd_pkg::HALF_PI_Q40)
            begin
                z5_next   = z4_reg[k] - gcd_pkg::PI_Q40;
                neg5_next = 1'b1;
            end
            else if (z4_reg[k] < -gcd_pkg::HALF_PI_Q40)
            begin
                z5_next   = z4_reg[k] + gcd_pkg::PI_Q40;
                neg5_next = 1'b1;
            end
            else
            begin
                z5_next   = z4_reg[k];
                neg5_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k]  <= mag_next;
                neg1_reg[k] <= raw[k] < 0;
                ph_reg[k]   <= 55'(mag_reg[k]) * 55'(gcd_pkg::D2R_HI);
                pl_reg[k]   <= 64'(mag_reg[k]) * 64'(gcd_pkg::D2R_LO);
                neg2_reg[k] <= neg1_reg[k];
                z3_reg[k]   <= z3_next;
                z4_reg[k]   <= z4_next;
                z5_reg[k]   <= z5_next;
                neg5_reg[k] <= neg5_next;
            end
        end

        gcd_sincos u_sincos (
            .clk     (clk),
            .en      (en),
            .z       (z5_reg[k]),
            .neg     (neg5_reg[k]),
            .sin_val (sin_w[k]),
            .cos_val (cos_w[k])
        );
    end

    // haversine term
    logic signed [31:0] s_dlat, c_a, c_b, s_dlon;
    logic signed [63:0] sq1_reg, cc_reg, sq2_reg, t_reg;
    logic signed [33:0] a1_reg;
    logic signed [35:0] hs;
    logic [30:0]        h_reg;
    logic [30:0]        h_next;
    logic [SQN*2-2:0]   vin_reg [2];

    assign s_dlat = 32'(sin_w[2]);
    assign c_a    = 32'(cos_w[0]);
    assign c_b    = 32'(cos_w[1]);
    assign s_dlon = 32'(sin_w[3]);
    assign hs     = 36'(a1_reg) + 36'(t_reg >>> 30);

    always_comb
    begin
        if (hs < 0)
            h_next = '0;
        else if (hs > ONE_S)
            h_next = gcd_pkg::ONE_Q30;
        else
            h_next = hs[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg    <= s_dlat * s_dlat;
            cc_reg     <= c_a * c_b;
            sq2_reg    <= s_dlon * s_dlon;
            a1_reg     <= 34'(sq1_reg >>> 30);
            t_reg      <= 32'(cc_reg >>> 30) * 32'(sq2_reg >>> 30);
            h_reg      <= h_next;
            vin_reg[0] <= {h_reg, 30'b0};
            vin_reg[1] <= {gcd_pkg::ONE_Q30 - h_reg, 30'b0};
        end
    end

    // digit-by-digit square roots: lane 0 sqrt(h), lane 1 sqrt(1-h)
    logic [gcd_pkg::SQ_W-1:0] sv_reg [2][SQN];
    logic [gcd_pkg::SQ_W-1:0] sr_reg [2][SQN];

    for (genvar l = 0; l < 2; l++) begin : g_sq
        for (genvar k = 0; k < SQN; k++) begin : g_step
            localparam logic [gcd_pkg::SQ_W-1:0] B = 62'd1 << (2 * (SQN - 1 - k));
            logic [gcd_pkg::SQ_W-1:0] v_cur;
            logic [gcd_pkg::SQ_W-1:0] r_cur;
            logic [gcd_pkg::SQ_W-1:0] t;

            if (k == 0) begin : g_first
                assign v_cur = gcd_pkg::SQ_W'(vin_reg[l]);
                assign r_cur = '0;
            end else begin : g_rest
                assign v_cur = sv_reg[l][k-1];
                assign r_cur = sr_reg[l][k-1];
            end

            assign t = r_cur + B;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (v_cur >= t)
                    begin
                        sv_reg[l][k] <= v_cur - t;
                        sr_reg[l][k] <= (r_cur >> 1) + B;
                    end
                    else
                    begin
                        sv_reg[l][k] <= v_cur;
                        sr_reg[l][k] <= r_cur >> 1;
                    end
                end
            end
        end
    end

    // vectoring CORDIC: central half angle
    logic signed [gcd_pkg::XY_W-1:0] vx_reg [N];
    logic signed [gcd_pkg::XY_W-1:0] vy_reg [N];
    logic signed [gcd_pkg::Z_W-1:0]  vz_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_vec
        logic signed [gcd_pkg::XY_W-1:0] x_cur;
        logic signed [gcd_pkg::XY_W-1:0] y_cur;
        logic signed [gcd_pkg::Z_W-1:0]  z_cur;
        logic signed [gcd_pkg::Z_W-1:0]  atn;

        if (i == 0) begin : g_first
            assign x_cur = $signed(sr_reg[1][SQN-1][gcd_pkg::XY_W-1:0]);
            assign y_cur = $signed(sr_reg[0][SQN-1][gcd_pkg::XY_W-1:0]);
            assign z_cur = '0;
        end else begin : g_rest
            assign x_cur = vx_reg[i-1];
            assign y_cur = vy_reg[i-1];
            assign z_cur = vz_reg[i-1];
        end

        assign atn = $signed(gcd_pkg::Z_W'(gcd_pkg::atan_q40(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_cur >= 0)
                begin
                    vx_reg[i] <= x_cur + (y_cur >>> i);
                    vy_reg[i] <= y_cur - (x_cur >>> i);
                    vz_reg[i] <= z_cur + atn;
                end
                else
                begin
                    vx_reg[i] <= x_cur - (y_cur >>> i);
                    vy_reg[i] <= y_cur + (x_cur >>> i);
                    vz_reg[i] <= z_cur - atn;
                end
            end
        end
    end

    // scale by radius * 10 and round
    logic [gcd_pkg::Z_W-1:0]    zr;
    logic [gcd_pkg::C32_W-1:0]  c32_reg;
    logic [gcd_pkg::C32_W-1:0]  c32_next;
    logic [62:0]                prod_reg;
    logic [62:0]                dsum;
    logic [30:0]                dq;
    logic [gcd_pkg::DIST_W-1:0] dist_reg;
    logic [gcd_pkg::DIST_W-1:0] dist_next;

    assign rad10    = {1'b0, earth_radius_m_reg, 3'b000} + {3'b000, earth_radius_m_reg, 1'b0};
    assign zr       = vz_reg[N-1] + gcd_pkg::Z_W'(64);
    assign c32_next = vz_reg[N-1] < 0 ? '0 : gcd_pkg::C32_W'(zr >> 7);
    assign dsum     = prod_reg + (63'd1 << 31);
    assign dq       = dsum[62:32];
    assign dist_next = (dq > 31'(gcd_pkg::MAX_DIST)) ? gcd_pkg::MAX_DIST : dq[27:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c32_reg  <= c32_next;
            prod_reg <= 63'(c32_reg) * 63'(rad10);
            dist_reg <= dist_next;
        end
    end

    assign result.valid    = vld_reg[LAT-1];
    assign result.distance = dist_reg;

endmodule

// ===== src/gcd_sincos.sv =====
// Pipelined rotation CORDIC: sine and cosine of a folded Q40 angle, one stage per iteration.
module gcd_sincos (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [gcd_pkg::Z_W-1:0]     z,
    input  logic                               neg,
    output logic signed [gcd_pkg::XY_W-1:0]    sin_val,
    output logic signed [gcd_pkg::XY_W-1:0]    cos_val
);

    localparam int N = gcd_pkg::CORDIC_STAGES;

    logic signed [gcd_pkg::XY_W-1:0] x_reg [N];
    logic signed [gcd_pkg::XY_W-1:0] y_reg [N];
    logic signed [gcd_pkg::Z_W-1:0]  z_reg [N];
    logic                            neg_reg [N];
    logic signed [gcd_pkg::XY_W-1:0] sin_reg;
    logic signed [gcd_pkg::XY_W-1:0] cos_reg;

    for (genvar i = 0; i < N; i++) begin : g_it
        logic signed [gcd_pkg::XY_W-1:0] x_cur;
        logic signed [gcd_pkg::XY_W-1:0] y_cur;
        logic signed [gcd_pkg::Z_W-1:0]  z_cur;
        logic                            neg_cur;
        logic signed [gcd_pkg::Z_W-1:0]  atn;

        if (i == 0) begin : g_first
            assign x_cur   = gcd_pkg::INV_K;
            assign y_cur   = '0;
            assign z_cur   = z;
            assign neg_cur = neg;
        end else begin : g_rest
            assign x_cur   = x_reg[i-1];
            assign y_cur   = y_reg[i-1];
            assign z_cur   = z_reg[i-1];
            assign neg_cur = neg_reg[i-1];
        end

        assign atn = $signed(gcd_pkg::Z_W'(gcd_pkg::atan_q40(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i] <= neg_cur;
                if (z_cur >= 0)
                begin
                    x_reg[i] <= x_cur - (y_cur >>> i);
                    y_reg[i] <= y_cur + (x_cur >>> i);
                    z_reg[i] <= z_cur - atn;
                end
                else
                begin
                    x_reg[i] <= x_cur + (y_cur >>> i);
                    y_reg[i] <= y_cur - (x_cur >>> i);
                    z_reg[i] <= z_cur + atn;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= neg_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];
            cos_reg <= neg_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== bench/gcd_checker.sv =====
// Checker: watches both channels, predicts each distance and compares in order.
`timescale 1ns / 100ps
module gcd_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    gcd_pts_if.sink                   points,
    gcd_dist_if.sink                  result,
    input  logic                      cfg_wr_en,
    input  logic [gcd_pkg::RAD_W-1:0] cfg_wr_data,
    output int                        errors,
    output int                        pending
);

    typedef logic [63:0] u64_t;

    logic [gcd_pkg::DIST_W-1:0] dist_q[$];
    logic [gcd_pkg::RAD_W-1:0]  radius;
    longint            atn_tbl[gcd_pkg::CORDIC_STAGES];
    u64_t              pi60_c, d2r60_c;
    longint            pi40_c, invk_c;

    function automatic u64_t root_floor(u64_t v);
        u64_t r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic u64_t arctan_inv(u64_t n);
        u64_t t, sum, k, term;
        t = (64'd1 << 60) / n;
        sum = 0;
        k = 0;
        while (t != 0)
        begin
            term = t / (2 * k + 1);
            if (k[0]) sum -= term; else sum += term;
            t = t / n / n;
            k++;
        end
        return sum;
    endfunction

    function automatic longint deg_to_rad(longint raw, int extra);
        int     s;
        u64_t   m, a;
        longint r;
        s = 20 + gcd_pkg::ANGLE_FRAC_BITS + extra;
        m = raw < 0 ? -raw : raw;
        a = m * (d2r60_c >> 32) + ((m * (d2r60_c & 64'hFFFF_FFFF)) >> 32)
            + (64'd1 << (s - 33));
        r = longint'(a >> (s - 32));
        return raw < 0 ? -r : r;
    endfunction

    function automatic void rotate(input longint z, output longint s, output longint c);
        longint x, y, xs, ys;
        bit     flip;
        x = invk_c;
        y = 0;
        flip = 0;
        while (z > pi40_c) z -= 2 * pi40_c;
        while (z < -pi40_c) z += 2 * pi40_c;
        if (z > (pi40_c >>> 1))
        begin
            z -= pi40_c;
            flip = 1;
        end
        else if (z < -(pi40_c >>> 1))
        begin
            z += pi40_c;
            flip = 1;
        end
        for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atn_tbl[i];
            end
            else
            begin
                x += ys; y -= xs; z += atn_tbl[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [gcd_pkg::DIST_W-1:0] predict_distance(longint la, longint oa,
                                                            longint lb, longint ob,
                                                            logic [gcd_pkg::RAD_W-1:0] rad);
        longint s1, c1, sa, ca, sb, cb, s2, c2, h, x, y, z, xs, ys;
        u64_t   c32, d;
        rotate(deg_to_rad(la, 0), sa, ca);
        rotate(deg_to_rad(lb, 0), sb, cb);
        rotate(deg_to_rad(la - lb, 1), s1, c1);
        rotate(deg_to_rad(oa - ob, 1), s2, c2);
        h = ((s1 * s1) >>> 30) + ((((ca * cb) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
        if (h < 0) h = 0;
        if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
        y = longint'(root_floor(u64_t'(h) << 30));
        x = longint'(root_floor(u64_t'((64'sd1 << 30) - h) << 30));
        z = 0;
        for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atn_tbl[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atn_tbl[i];
            end
        end
        if (z < 0) z = 0;
        c32 = (u64_t'(2 * z) + 128) >> 8;
        d = (c32 * (u64_t'(rad) * 10) + (64'd1 << 31)) >> 32;
        if (d > gcd_pkg::MAX_DIST) d = gcd_pkg::MAX_DIST;
        return d[gcd_pkg::DIST_W-1:0];
    endfunction

    initial
    begin
        u64_t p, a60;
        pi60_c = 4 * (4 * arctan_inv(5) - arctan_inv(239));
        pi40_c = longint'((pi60_c + (64'd1 << 19)) >> 20);
        d2r60_c = pi60_c / 180;
        p = 64'd1 << 60;
        for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++)
        begin
            a60 = (i == 0) ? pi60_c / 4 : arctan_inv(64'd1 << i);
            atn_tbl[i] = longint'((a60 + (64'd1 << 19)) >> 20);
            if (2 * i < 64) p += p >> (2 * i);
        end
        invk_c = longint'((64'd1 << 60) / root_floor(p));
    end

    assign pending = dist_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [gcd_pkg::DIST_W-1:0] want;
        if (!rst_n)
        begin
            radius <= gcd_pkg::RADIUS_RESET;
            errors <= 0;
            dist_q.delete();
        end
        else
        begin
            if (points.valid && points.ready)
                dist_q.push_back(predict_distance(points.lat_a, points.lon_a,
                                                  points.lat_b, points.lon_b, radius));
            if (result.valid && result.ready)
            begin
                if (dist_q.size() == 0)
                begin
                    $error("unexpected transaction: distance actual %0d", result.distance);
                    errors <= errors + 1;
                end
                else
                begin
                    want = dist_q.pop_front();
                    if (want !== result.distance)
                    begin
                        $error("distance: expected %0d actual %0d", want, result.distance);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_wr_en)
                radius <= cfg_wr_data;
        end
    end
endmodule

// ===== bench/tb.sv =====
// Testbench top: drives points, radius writes and result back-pressure; gives the verdict.
`timescale 1ns / 100ps
module tb;

    localparam int LAT_MAX = 377487360;
    localparam int LON_MAX = 754974720;
    localparam int RAND_ITEMS = 1530;
    localparam int LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [gcd_pkg::RAD_W-1:0] cfg_wr_data = '0;
    int   errors, pending;
    int   cycles = 0;
    bit   sending = 1;

    gcd_pts_if  points();
    gcd_dist_if result();

    great_circle_distance u_top (
        .clk(clk), .rst_n(rst_n), .points(points), .result(result),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    gcd_checker u_chk (
        .clk(clk), .rst_n(rst_n), .points(points), .result(result),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    always #2 clk = ~clk;

    initial
    begin
        points.valid = 0;
        points.lat_a = '0;
        points.lon_a = '0;
        points.lat_b = '0;
        points.lon_b = '0;
        result.ready = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // sink stall: random wait before each ready, with calm stretches
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (sending && $urandom_range(0, 7) == 0) gap = 0;
            repeat (gap) @(posedge clk);
            result.ready <= 1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
            result.ready <= 0;
        end
    end

    task automatic send(input int la, input int oa, input int lb, input int ob,
                        input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            points.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        points.valid <= 1;
        points.lat_a <= gcd_pkg::LAT_W'(la);
        points.lon_a <= gcd_pkg::LON_W'(oa);
        points.lat_b <= gcd_pkg::LAT_W'(lb);
        points.lon_b <= gcd_pkg::LON_W'(ob);
        @(posedge clk);
        while (!points.ready) @(posedge clk);
    endtask

    task automatic set_radius(input logic [gcd_pkg::RAD_W-1:0] r);
        points.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (110) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    function automatic int rnd(int m);
        case ($urandom_range(0, 5))
            0: return m;
            1: return -m;
            2: return $urandom_range(0, 1) ? 0 : $urandom_range(0, 4096) - 2048;
            3: return int'($urandom) >>> 1;
            default: return int'($urandom_range(0, 2 * m)) - m;
        endcase
    endfunction

    initial
    begin
        logic [gcd_pkg::RAD_W-1:0] radii[5];
        bit burst;
        radii = '{23'd6378137, 23'd1, 23'h7FFFFF, 23'd0, 23'd6371000};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(0, 0, 0, 0, 0);
        send(LAT_MAX, 0, -LAT_MAX, 0, 0);
        send(0, LON_MAX, 0, -LON_MAX, 0);
        send(0, 0, 0, LON_MAX, 0);
        send(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 1);
        send(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1);
        send(30'sh1FFFFFFF, 31'sh3FFFFFFF, -30'sh20000000, -31'sh40000000, 1);
        send(-30'sh20000000, -31'sh40000000, 30'sh1FFFFFFF, 31'sh3FFFFFFF, 0);
        send(LAT_MAX + 1000000, 0, -LAT_MAX - 1000000, 1000, 0);
        send(12345678, 23456789, 12345679, 23456789, 0);
        send(-5, 7, 5, -7, 0);
        send(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 4, -LON_MAX / 5, 0);
        for (int ph = 0; ph < 5; ph++)
        begin
            set_radius(radii[ph]);
            send(LAT_MAX, 0, -LAT_MAX, 0, 0);
            send(0, 0, 0, LON_MAX, 0);
            burst = 0;
            for (int i = 0; i < RAND_ITEMS / 5; i++)
            begin
                if ($urandom_range(0, 19) == 0) burst = ~burst;
                send(rnd(LAT_MAX), rnd(LON_MAX), rnd(LAT_MAX), rnd(LON_MAX), burst);
            end
        end
        points.valid <= 0;
        sending = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== great_circle_distance.f =====
src/gcd_pkg.sv
src/gcd_pts_if.sv
src/gcd_dist_if.sv
src/gcd_sincos.sv
src/great_circle_distance.sv
bench/gcd_checker.sv
bench/tb.sv
